[rtl/core/qco_pkg.sv]
// ----------------------------------------------------------------------------
// qco_pkg: shared types and constants for quadrilateral corner ordering
// Coordinate widths, corner and beat structs, and the sort rank type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qco_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;
  localparam int NUM_PTS    = 4;

  typedef logic [1:0] rank_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } corner_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] top_left_x;
    logic signed [COORD_BITS-1:0] top_left_y;
    logic signed [COORD_BITS-1:0] top_right_x;
    logic signed [COORD_BITS-1:0] top_right_y;
    logic signed [COORD_BITS-1:0] bottom_right_x;
    logic signed [COORD_BITS-1:0] bottom_right_y;
    logic signed [COORD_BITS-1:0] bottom_left_x;
    logic signed [COORD_BITS-1:0] bottom_left_y;
  } out_beat_t;

endpackage

[rtl/core/quad_corner_ordering.sv]
// ----------------------------------------------------------------------------
// quad_corner_ordering: order four quadrilateral corners TL, TR, BR, BL
// Throughput: one quadrilateral per cycle unless an output stall holds the
// full pipe; the squarer stage and the distance compare each hold their
// own register stage in a six-deep pipe.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_corner_ordering (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qco_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qco_pkg::out_beat_t out_data_o
);
  import qco_pkg::*;

  // Stage map:
  //   1: capture corners and their stable x-ranks
  //   2: scatter into sorted order, pick top-left / bottom-left by y
  //   3: absolute x/y differences of the right pair against top-left
  //   4: squares (four MAG_BITS x MAG_BITS multipliers)
  //   5: squared distances (one add each)
  //   6: compare distances, build the result beat (output register)
  // Each stage loads when empty or when the stage after it moves on,
  // so bubbles collapse and a stalled output does not block upstream
  // until the whole pipe is full.

  logic [6:1] vld_q;
  logic [7:1] rdy;

  always_comb begin
    rdy[7] = !out_stall_i;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  logic [6:1] vld_in;
  assign vld_in = {vld_q[5:1], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= 6; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  logic [6:1] load;
  assign load = rdy[6:1] & vld_in;

  // ---- stage 1: corners and ranks -----------------------------------------
  corner_t [3:0] pts_in;
  rank_t   [3:0] rank_in;
  corner_t [3:0] pts1_q;
  rank_t   [3:0] rank1_q;

  assign pts_in[0] = '{x: in_data_i.p0_x, y: in_data_i.p0_y};
  assign pts_in[1] = '{x: in_data_i.p1_x, y: in_data_i.p1_y};
  assign pts_in[2] = '{x: in_data_i.p2_x, y: in_data_i.p2_y};
  assign pts_in[3] = '{x: in_data_i.p3_x, y: in_data_i.p3_y};

  qco_rank u_rank (
    .pts_i  (pts_in),
    .rank_o (rank_in)
  );

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      pts1_q  <= pts_in;
      rank1_q <= rank_in;
    end
  end

  // ---- stage 2: sorted order and left pair --------------------------------
  corner_t [3:0] srt;
  corner_t       tl2_d, bl2_d;
  corner_t       tl2_q, bl2_q, ra2_q, rb2_q;

  always_comb begin
    srt = pts1_q;
    for (int p = 0; p < NUM_PTS; p++) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        if (rank1_q[i] == rank_t'(p)) begin
          srt[p] = pts1_q[i];
        end
      end
    end
    // Strictly smaller y wins top-left; on a tie the second sorted corner.
    if ($signed(srt[0].y) < $signed(srt[1].y)) begin
      tl2_d = srt[0];
      bl2_d = srt[1];
    end else begin
      tl2_d = srt[1];
      bl2_d = srt[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      tl2_q <= tl2_d;
      bl2_q <= bl2_d;
      ra2_q <= srt[2];
      rb2_q <= srt[3];
    end
  end

  // ---- stage 3: absolute differences --------------------------------------
  function automatic logic [MAG_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] d;
    d = DIFF_BITS'(a) - DIFF_BITS'(b);
    if (d[DIFF_BITS-1]) begin
      d = -d;
    end
    return d[MAG_BITS-1:0];
  endfunction

  corner_t             tl3_q, bl3_q, ra3_q, rb3_q;
  logic [MAG_BITS-1:0] dax3_q, day3_q, dbx3_q, dby3_q;

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      tl3_q  <= tl2_q;
      bl3_q  <= bl2_q;
      ra3_q  <= ra2_q;
      rb3_q  <= rb2_q;
      dax3_q <= abs_diff(ra2_q.x, tl2_q.x);
      day3_q <= abs_diff(ra2_q.y, tl2_q.y);
      dbx3_q <= abs_diff(rb2_q.x, tl2_q.x);
      dby3_q <= abs_diff(rb2_q.y, tl2_q.y);
    end
  end

  // ---- stage 4: squares ---------------------------------------------------
  corner_t            tl4_q, bl4_q, ra4_q, rb4_q;
  logic [SQ_BITS-1:0] sax4_q, say4_q, sbx4_q, sby4_q;

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      tl4_q  <= tl3_q;
      bl4_q  <= bl3_q;
      ra4_q  <= ra3_q;
      rb4_q  <= rb3_q;
      sax4_q <= SQ_BITS'(dax3_q) * SQ_BITS'(dax3_q);
      say4_q <= SQ_BITS'(day3_q) * SQ_BITS'(day3_q);
      sbx4_q <= SQ_BITS'(dbx3_q) * SQ_BITS'(dbx3_q);
      sby4_q <= SQ_BITS'(dby3_q) * SQ_BITS'(dby3_q);
    end
  end

  // ---- stage 5: squared distances -----------------------------------------
  corner_t              tl5_q, bl5_q, ra5_q, rb5_q;
  logic [DIST_BITS-1:0] da5_q, db5_q;

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      tl5_q <= tl4_q;
      bl5_q <= bl4_q;
      ra5_q <= ra4_q;
      rb5_q <= rb4_q;
      da5_q <= DIST_BITS'(sax4_q) + DIST_BITS'(say4_q);
      db5_q <= DIST_BITS'(sbx4_q) + DIST_BITS'(sby4_q);
    end
  end

  // ---- stage 6: right pair and result beat --------------------------------
  out_beat_t out_d, out_q;

  always_comb begin
    out_d.top_left_x    = tl5_q.x;
    out_d.top_left_y    = tl5_q.y;
    out_d.bottom_left_x = bl5_q.x;
    out_d.bottom_left_y = bl5_q.y;
    // Third sorted corner goes bottom-right only when strictly farther.
    if (da5_q > db5_q) begin
      out_d.bottom_right_x = ra5_q.x;
      out_d.bottom_right_y = ra5_q.y;
      out_d.top_right_x    = rb5_q.x;
      out_d.top_right_y    = rb5_q.y;
    end else begin
      out_d.bottom_right_x = rb5_q.x;
      out_d.bottom_right_y = rb5_q.y;
      out_d.top_right_x    = ra5_q.x;
      out_d.top_right_y    = ra5_q.y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = vld_q[6];
  assign out_data_o  = out_q;

  // ---- assertions ---------------------------------------------------------
  // Input may only stall once every stage holds a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while the pipe has a bubble");

  // Stable ranks must form a permutation.
  a_rank_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> ((rank1_q[0] != rank1_q[1]) && (rank1_q[0] != rank1_q[2]) &&
                  (rank1_q[0] != rank1_q[3]) && (rank1_q[1] != rank1_q[2]) &&
                  (rank1_q[1] != rank1_q[3]) && (rank1_q[2] != rank1_q[3])))
    else $error("x-ranks are not a permutation");

  // Left pair never lies right of the right pair, and top-left is not below.
  a_left_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (($signed(out_data_o.top_left_x) <= $signed(out_data_o.top_right_x)) &&
       ($signed(out_data_o.bottom_left_x) <= $signed(out_data_o.bottom_right_x)) &&
       ($signed(out_data_o.top_left_y) <= $signed(out_data_o.bottom_left_y))))
    else $error("result corners out of order");

endmodule

[rtl/core/qco_rank.sv]
// ----------------------------------------------------------------------------
// qco_rank: stable x-rank of four corners
// Each corner's rank counts corners with smaller x, plus earlier corners
// with equal x, so the ranks form a permutation of a stable sort.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qco_rank (
  input  qco_pkg::corner_t [3:0] pts_i,
  output qco_pkg::rank_t   [3:0] rank_o
);
  import qco_pkg::*;

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      rank_o[i] = '0;
      for (int j = 0; j < NUM_PTS; j++) begin
        if (j != i) begin
          if (($signed(pts_i[j].x) < $signed(pts_i[i].x)) ||
              ((pts_i[j].x == pts_i[i].x) && (j < i))) begin
            rank_o[i] = rank_o[i] + rank_t'(1);
          end
        end
      end
    end
  end

endmodule
